[rtl/mbg_pkg.sv]
`default_nettype none

package mbg_pkg;

  // grid size limits and reset value of the side register
  localparam int MAX_SIDE_DEF = 64;
  localparam int SIDE_MIN     = 2;
  localparam int SIDE_RESET   = 16;

  // field widths
  localparam int CFG_W      = 7;
  localparam int RND_W      = 15;
  localparam int CELL_OUT_W = 12;
  localparam int IN_TDATA_W = 16;
  localparam int TDATA_W    = 32;
  localparam int OUT_PAD_W  = TDATA_W - 2 * CELL_OUT_W - 2;

  // x mod 3 by reciprocal: q = (x * RECIP) >> SHIFT is exact for 15-bit x
  localparam int MOD3_RECIP = 43691;
  localparam int MOD3_SHIFT = 17;

  // neighbor order is also the carve direction code
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_e;

endpackage

`default_nettype wire

[rtl/mbg_ram.sv]
`default_nettype none

module mbg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/mbg_nbr_unit.sv]
`default_nettype none

// shared neighbor address unit: one add/subtract plus the grid bound checks
module mbg_nbr_unit #(
  parameter int MAX_SIDE = mbg_pkg::MAX_SIDE_DEF
) (
  input  wire logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   cur_i,
  input  wire logic [$clog2(MAX_SIDE)-1:0]            col_i,
  input  wire logic [$clog2(MAX_SIDE+1)-1:0]          side_i,
  input  wire logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0] total_i,
  input  wire mbg_pkg::dir_e                          dir_i,
  output logic      [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   addr_o,
  output logic                                        inb_o
);

  localparam int CELL_W  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int TOTAL_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int SW      = TOTAL_W + 1;

  logic [SW-1:0]     opa;
  logic [SW-1:0]     opb;
  logic [SW-1:0]     sum;
  logic              sub;
  logic [SIDE_W:0]   col_p1;

  always_comb begin
    opa    = SW'(cur_i);
    opb    = ((dir_i == mbg_pkg::DIR_UP) || (dir_i == mbg_pkg::DIR_DOWN)) ?
             SW'(side_i) : SW'(1);
    sub    = (dir_i == mbg_pkg::DIR_UP) || (dir_i == mbg_pkg::DIR_LEFT);
    sum    = sub ? (opa - opb) : (opa + opb);
    col_p1 = (SIDE_W + 1)'(col_i) + (SIDE_W + 1)'(1);
    case (dir_i)
      mbg_pkg::DIR_UP:    inb_o = (opa >= opb);
      mbg_pkg::DIR_RIGHT: inb_o = (col_p1 != (SIDE_W + 1)'(side_i));
      mbg_pkg::DIR_DOWN:  inb_o = (sum < SW'(total_i));
      mbg_pkg::DIR_LEFT:  inb_o = (col_i != '0);
      default:            inb_o = 1'b0;
    endcase
    addr_o = sum[CELL_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/mbg_pick.sv]
`default_nettype none

// picks entry (random mod count) among the open neighbors
module mbg_pick (
  input  wire logic [3:0]                 mask_i,
  input  wire logic [mbg_pkg::RND_W-1:0]  rnd_i,
  output logic                            any_o,
  output mbg_pkg::dir_e                   dir_o
);

  logic [2:0]  cnt;
  logic [31:0] prod;
  logic [14:0] q3;
  logic [16:0] q3x3;
  logic [1:0]  r3;
  logic [1:0]  k;
  logic [2:0]  seen;

  always_comb begin
    cnt  = 3'(mask_i[0]) + 3'(mask_i[1]) + 3'(mask_i[2]) + 3'(mask_i[3]);
    prod = 32'(rnd_i) * 32'(mbg_pkg::MOD3_RECIP);
    q3   = 15'(prod >> mbg_pkg::MOD3_SHIFT);
    q3x3 = {2'b00, q3} + {1'b0, q3, 1'b0};
    r3   = 2'(17'(rnd_i) - q3x3);
    case (cnt)
      3'd2:    k = {1'b0, rnd_i[0]};
      3'd3:    k = r3;
      3'd4:    k = rnd_i[1:0];
      default: k = 2'd0;
    endcase
    any_o = (cnt != 3'd0);
    dir_o = mbg_pkg::DIR_UP;
    seen  = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (mask_i[i]) begin
        if (seen == {1'b0, k}) begin
          dir_o = mbg_pkg::dir_e'(2'(i));
        end
        seen = seen + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/maze_backtracker_generator_top.sv]
`default_nettype none

// randomized depth-first maze generator over a side x side grid, cells
// numbered row-major from 0. each input transaction carries one random word
// and runs one step: the unvisited neighbors of the current cell are gathered
// in the order up, right, down, left, entry (random mod count) is carved to
// and the current cell is pushed; with no open neighbor the stack is popped.
// one result transaction comes out per input: tlast marks the carve that
// completes the maze, after which generation starts over from cell 0.
// a step runs through the states idle (accept), probe (once per neighbor,
// through the single read port of the visited memory), last (read latency),
// pick, commit and finish; the visited memory has one write port, so commit
// marks the current cell and finish the cell carved to. finish waits while
// the result slot is full and not taken. after reset, after a write of side
// and after each completed maze the visited memory is cleared one cell per
// cycle over all side*side cells, while s_axis_tready stays low. the user must
// write side through cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce it.
module maze_backtracker_generator_top #(
  parameter int MAX_SIDE = mbg_pkg::MAX_SIDE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration: side
  input  wire logic                            cfg_we_i,
  input  wire logic [mbg_pkg::CFG_W-1:0]       cfg_wdata_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [mbg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // random_word[14:0]
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [mbg_pkg::TDATA_W-1:0]     m_axis_tdata,   // from_cell, to_cell, direction
  output logic                                 m_axis_tuser,   // carved
  output logic                                 m_axis_tlast    // done_res
);

  localparam int CELLS     = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int TOTAL_W   = $clog2(CELLS + 1);
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int COL_W     = $clog2(MAX_SIDE);
  localparam int STK_W     = COL_W + CELL_W;
  localparam int RST_SIDE  = (mbg_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE :
                             mbg_pkg::SIDE_RESET;
  localparam int OW        = mbg_pkg::CELL_OUT_W;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_PROBE  = 7'b0000100,
    ST_LAST   = 7'b0001000,
    ST_PICK   = 7'b0010000,
    ST_COMMIT = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  // control state
  state_e               state_q, state_d;
  logic [CELL_W-1:0]    clr_q, clr_d;
  logic [CELL_W-1:0]    cur_q, cur_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [TOTAL_W-1:0]   depth_q, depth_d;
  logic [TOTAL_W-1:0]   count_q, count_d;
  logic [SIDE_W-1:0]    side_q, side_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  mbg_pkg::dir_e        pcnt_q, pcnt_d;
  logic                 pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;

  // step payload
  logic [mbg_pkg::RND_W-1:0] rnd_q;
  logic [3:0]                mask_q;
  mbg_pkg::dir_e             pdir_q;
  logic                      pinb_q;
  logic [CELL_W-1:0]         nxt_q;
  logic [COL_W-1:0]          nxt_col_q;
  mbg_pkg::dir_e             dir_q;
  logic                      carve_q;

  // result register
  logic [OW-1:0]             out_from_q;
  logic [OW-1:0]             out_to_q;
  mbg_pkg::dir_e             out_dir_q;
  logic                      out_carved_q;
  logic                      out_done_q;

  // datapath signals
  logic [SIDE_W-1:0]         cfg_side;
  logic [TOTAL_W-1:0]        total_m1;
  logic [TOTAL_W-1:0]        depth_m1;
  logic [TOTAL_W-1:0]        count_inc;
  logic                      stk_room;
  mbg_pkg::dir_e             nbr_dir;
  logic [CELL_W-1:0]         nbr_addr;
  logic                      nbr_inb;
  logic                      pick_any;
  mbg_pkg::dir_e             pick_dir;
  logic [COL_W-1:0]          pick_col;
  logic                      vis_we;
  logic [CELL_W-1:0]         vis_waddr;
  logic [0:0]                vis_wdata;
  logic                      vis_re;
  logic [0:0]                vis_rdata;
  logic                      stk_we;
  logic                      stk_re;
  logic [STK_W-1:0]          stk_rdata;
  logic [CELL_W-1:0]         stk_cell;
  logic [COL_W-1:0]          stk_col;
  logic                      out_load;
  logic                      restart;
  logic                      in_xfer;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign total_m1  = total_q - TOTAL_W'(1);
  assign depth_m1  = depth_q - TOTAL_W'(1);
  assign count_inc = count_q + TOTAL_W'(1);
  assign stk_room  = (depth_q < TOTAL_W'(CELLS));
  assign stk_cell  = stk_rdata[CELL_W-1:0];
  assign stk_col   = stk_rdata[STK_W-1:CELL_W];

  // side register is kept clamped, together with the cell count
  always_comb begin
    if (cfg_wdata_i < mbg_pkg::CFG_W'(mbg_pkg::SIDE_MIN)) begin
      cfg_side = SIDE_W'(mbg_pkg::SIDE_MIN);
    end else if (32'(cfg_wdata_i) > 32'(MAX_SIDE)) begin
      cfg_side = SIDE_W'(MAX_SIDE);
    end else begin
      cfg_side = SIDE_W'(cfg_wdata_i);
    end
    side_d  = cfg_we_i ? cfg_side : side_q;
    total_d = cfg_we_i ? TOTAL_W'({{SIDE_W{1'b0}}, cfg_side} * {{SIDE_W{1'b0}}, cfg_side})
                       : total_q;
  end

  mbg_nbr_unit #(
    .MAX_SIDE (MAX_SIDE)
  ) u_nbr (
    .cur_i   (cur_q),
    .col_i   (col_q),
    .side_i  (side_q),
    .total_i (total_q),
    .dir_i   (nbr_dir),
    .addr_o  (nbr_addr),
    .inb_o   (nbr_inb)
  );

  mbg_pick u_pick (
    .mask_i (mask_q),
    .rnd_i  (rnd_q),
    .any_o  (pick_any),
    .dir_o  (pick_dir)
  );

  always_comb begin
    case (pick_dir)
      mbg_pkg::DIR_RIGHT: pick_col = col_q + COL_W'(1);
      mbg_pkg::DIR_LEFT:  pick_col = col_q - COL_W'(1);
      default:            pick_col = col_q;
    endcase
  end

  // visited map, cleared by a sweep
  mbg_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (vis_re),
    .raddr_i (nbr_addr),
    .rdata_o (vis_rdata)
  );

  // backtrack stack, entries hold {column, cell}
  mbg_ram #(
    .WIDTH (STK_W),
    .DEPTH (CELLS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q[CELL_W-1:0]),
    .wdata_i ({col_q, cur_q}),
    .re_i    (stk_re),
    .raddr_i (depth_m1[CELL_W-1:0]),
    .rdata_o (stk_rdata)
  );

  // step sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    col_d       = col_q;
    depth_d     = depth_q;
    count_d     = count_q;
    pcnt_d      = pcnt_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    nbr_dir     = pcnt_q;
    vis_we      = 1'b0;
    vis_waddr   = cur_q;
    vis_wdata   = 1'b1;
    vis_re      = 1'b0;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    out_load    = 1'b0;
    restart     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = 1'b0;
        if (TOTAL_W'(clr_q) == total_m1) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + CELL_W'(1);
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_PROBE;
          pcnt_d  = mbg_pkg::DIR_UP;
        end
      end
      ST_PROBE: begin
        // one neighbor read per cycle, result captured in the following cycle
        vis_re = nbr_inb;
        pend_d = 1'b1;
        if (pcnt_q == mbg_pkg::DIR_LEFT) begin
          state_d = ST_LAST;
        end else begin
          pcnt_d = mbg_pkg::dir_e'(2'(pcnt_q) + 2'd1);
        end
      end
      ST_LAST: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        nbr_dir = pick_dir;
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        // mark the current cell, then push it or start the pop read
        vis_we = 1'b1;
        if (carve_q) begin
          stk_we = stk_room;
        end else begin
          stk_re = (depth_q != '0);
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (carve_q) begin
            vis_we    = 1'b1;
            vis_waddr = nxt_q;
            cur_d     = nxt_q;
            col_d     = nxt_col_q;
            count_d   = count_inc;
            if (stk_room) begin
              depth_d = depth_q + TOTAL_W'(1);
            end
            if (count_inc >= total_q) begin
              restart = 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            if (depth_q != '0) begin
              depth_d = depth_m1;
              cur_d   = stk_cell;
              col_d   = stk_col;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase

    // fresh maze after completion or a side write
    if (restart || cfg_we_i) begin
      state_d = ST_CLEAR;
      clr_d   = '0;
      cur_d   = '0;
      col_d   = '0;
      depth_d = '0;
      count_d = TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      col_q       <= '0;
      depth_q     <= '0;
      count_q     <= TOTAL_W'(1);
      side_q      <= SIDE_W'(RST_SIDE);
      total_q     <= TOTAL_W'(RST_SIDE * RST_SIDE);
      pcnt_q      <= mbg_pkg::DIR_UP;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      col_q       <= col_d;
      depth_q     <= depth_d;
      count_q     <= count_d;
      side_q      <= side_d;
      total_q     <= total_d;
      pcnt_q      <= pcnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // step payload
  always_ff @(posedge clk_i) begin
    pdir_q <= pcnt_q;
    pinb_q <= nbr_inb;
    if (in_xfer) begin
      rnd_q  <= s_axis_tdata[mbg_pkg::RND_W-1:0];
      mask_q <= '0;
    end else if (pend_q) begin
      mask_q[2'(pdir_q)] <= pinb_q && !vis_rdata[0];
    end
    if (state_q == ST_PICK) begin
      nxt_q     <= nbr_addr;
      nxt_col_q <= pick_col;
      dir_q     <= pick_dir;
      carve_q   <= pick_any;
    end
  end

  // result register, parts the output handshake from the sequencer
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_from_q   <= OW'(cur_q);
      out_carved_q <= carve_q;
      out_done_q   <= carve_q && (count_inc >= total_q);
      if (carve_q) begin
        out_to_q  <= OW'(nxt_q);
        out_dir_q <= dir_q;
      end else begin
        out_to_q  <= (depth_q != '0) ? OW'(stk_cell) : OW'(cur_q);
        out_dir_q <= mbg_pkg::DIR_UP;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{mbg_pkg::OUT_PAD_W{1'b0}}, out_dir_q, out_to_q, out_from_q};
  assign m_axis_tuser  = out_carved_q;
  assign m_axis_tlast  = out_done_q;

`ifndef ASSERT_OFF
  // every stacked cell was counted as visited first
  a_depth_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q < count_q)
    else $error("stack depth reached visited count");

  // current cell stays inside the configured grid
  a_cur_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    TOTAL_W'(cur_q) < total_q)
    else $error("current cell outside grid");

  // a completed maze is always reported on a carve
  a_done_is_carve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("maze completion without carve");

  // completion restarts with a clearing sweep before the next step
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && carve_q && (count_inc >= total_q) && !cfg_we_i |=> state_q == ST_CLEAR)
    else $error("no clearing sweep after completion");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
module tb_top;

  // grid limits as built into the block
  localparam int MAX_SIDE  = mbg_pkg::MAX_SIDE_DEF;
  localparam int CELLS     = MAX_SIDE * MAX_SIDE;
  // base unit of the settling waits after drain_results
  localparam int STEP_LATENCY = 9;
  // generous cycle limit for the whole run, enforced by the watchdog
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 144;

  // one result transaction as the block should report it
  typedef struct {
    logic [mbg_pkg::CELL_OUT_W-1:0] from_cell;
    logic [mbg_pkg::CELL_OUT_W-1:0] to_cell;
    mbg_pkg::dir_e                  direction;
    logic                           carved;
    logic                           done;
  } passage_t;

  // keeps its own copy of the maze state and predicts each step
  class passage_scoreboard;
    bit                             visited [CELLS];
    logic [mbg_pkg::CELL_OUT_W-1:0] backtrack [CELLS];
    int unsigned                    depth;
    int unsigned                    cur_cell;
    int unsigned                    visited_cnt;
    logic [mbg_pkg::CFG_W-1:0]      side_reg;
    passage_t                       expected_passages [$];
    int unsigned                    failures;

    function new();
      side_reg = mbg_pkg::CFG_W'(mbg_pkg::SIDE_RESET);
      failures = 0;
      restart();
    endfunction

    function void restart();
      foreach (visited[i]) visited[i] = 1'b0;
      depth       = 0;
      cur_cell    = 0;
      visited_cnt = 1;
    endfunction

    // a side write starts a fresh maze
    function void set_side(logic [mbg_pkg::CFG_W-1:0] value);
      side_reg = value;
      restart();
    endfunction

    function int unsigned pending();
      return expected_passages.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    // one generation step for an accepted random word
    function void note_random_word(logic [mbg_pkg::RND_W-1:0] rnd);
      int unsigned   s, total, cur, col, n, k, nxt;
      int unsigned   cand [4];
      mbg_pkg::dir_e dirs [4];
      passage_t      p;
      s     = (side_reg < mbg_pkg::SIDE_MIN) ? mbg_pkg::SIDE_MIN :
              ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
      total = s * s;
      cur   = cur_cell % total;
      col   = cur % s;
      n     = 0;
      if (cur >= s && !visited[cur - s]) begin
        cand[n] = cur - s; dirs[n] = mbg_pkg::DIR_UP; n++;
      end
      if (col < s - 1 && !visited[cur + 1]) begin
        cand[n] = cur + 1; dirs[n] = mbg_pkg::DIR_RIGHT; n++;
      end
      if (cur + s < total && !visited[cur + s]) begin
        cand[n] = cur + s; dirs[n] = mbg_pkg::DIR_DOWN; n++;
      end
      if (col != 0 && !visited[cur - 1]) begin
        cand[n] = cur - 1; dirs[n] = mbg_pkg::DIR_LEFT; n++;
      end
      p.from_cell = mbg_pkg::CELL_OUT_W'(cur);
      p.to_cell   = mbg_pkg::CELL_OUT_W'(cur);
      p.direction = mbg_pkg::DIR_UP;
      p.carved    = 1'b0;
      p.done      = 1'b0;
      if (n > 0) begin
        k   = rnd % n;
        nxt = cand[k];
        visited[cur] = 1'b1;
        visited[nxt] = 1'b1;
        if (depth < CELLS) begin
          backtrack[depth] = mbg_pkg::CELL_OUT_W'(cur);
          depth++;
        end
        cur_cell = nxt;
        visited_cnt++;
        p.to_cell   = mbg_pkg::CELL_OUT_W'(nxt);
        p.direction = dirs[k];
        p.carved    = 1'b1;
        if (visited_cnt >= total) begin
          p.done = 1'b1;
          restart();
        end
      end else begin
        visited[cur] = 1'b1;
        if (depth > 0) begin
          depth--;
          p.to_cell = mbg_pkg::CELL_OUT_W'(backtrack[depth] % total);
        end
        cur_cell = 32'(p.to_cell);
      end
      expected_passages.push_back(p);
    endfunction

    // compare one accepted result against the oldest prediction
    function void check_passage(logic [mbg_pkg::TDATA_W-1:0] tdata, logic carved,
                                logic done);
      passage_t want;
      if (expected_passages.size() == 0) begin
        flag($sformatf("result with nothing expected: tdata=%h carved=%b done=%b",
                       tdata, carved, done));
        return;
      end
      want = expected_passages.pop_front();
      if (tdata[mbg_pkg::CELL_OUT_W-1:0] !== want.from_cell ||
          tdata[2*mbg_pkg::CELL_OUT_W-1:mbg_pkg::CELL_OUT_W] !== want.to_cell ||
          tdata[2*mbg_pkg::CELL_OUT_W+1:2*mbg_pkg::CELL_OUT_W] !== want.direction ||
          carved !== want.carved || done !== want.done) begin
        flag($sformatf({"exp from=%0d to=%0d dir=%0d carved=%b done=%b, ",
                        "got from=%0d to=%0d dir=%0d carved=%b done=%b"},
                       want.from_cell, want.to_cell, want.direction, want.carved,
                       want.done, tdata[mbg_pkg::CELL_OUT_W-1:0],
                       tdata[2*mbg_pkg::CELL_OUT_W-1:mbg_pkg::CELL_OUT_W],
                       tdata[2*mbg_pkg::CELL_OUT_W+1:2*mbg_pkg::CELL_OUT_W],
                       carved, done));
      end
    endfunction
  endclass

  // block ports
  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [mbg_pkg::CFG_W-1:0]      cfg_wdata_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [mbg_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [mbg_pkg::TDATA_W-1:0]    m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;

  // idling controls, percent of cycles
  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;

  passage_scoreboard sb;

  maze_backtracker_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // random_word[14:0], zero pad above
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // from_cell, to_cell, direction, zero pad above
    .m_axis_tuser  (m_axis_tuser),    // carved
    .m_axis_tlast  (m_axis_tlast)     // done_res
  );

  // 8 unit clock period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // transaction monitors and random receiver stalls; values sampled at the
  // edge are the ones from before this edge's updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_passage(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_random_word(s_axis_tdata[mbg_pkg::RND_W-1:0]);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // mostly uniform words, with the all-zero and all-one extremes mixed in
  function automatic logic [mbg_pkg::RND_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return mbg_pkg::RND_W'($urandom_range(0, (1 << mbg_pkg::RND_W) - 1));
    endcase
  endfunction

  // present one word, optionally after a random idle gap, and wait for the
  // transaction; returns at the accepting edge with tvalid still high
  task automatic send_word(input logic [mbg_pkg::RND_W-1:0] word);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(mbg_pkg::IN_TDATA_W - mbg_pkg::RND_W){1'b0}}, word};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // side is only written with the block idle and its clear pass finished
  task automatic write_side(input logic [mbg_pkg::CFG_W-1:0] value);
    drain_results();
    repeat (2 * STEP_LATENCY) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    sb.set_side(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // side settings for the random phases: mostly small grids for frequent
  // completions, plus the largest grid and out of range values
  int phase_sides [12] = '{3, 2, 5, 64, 4, 8, 127, 6, 1, 10, 3, 0};

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset side of 16, word extremes
    send_word('0);
    send_word('1);
    send_word(mbg_pkg::RND_W'(1));
    send_word(mbg_pkg::RND_W'(2));
    send_word(mbg_pkg::RND_W'(3));

    // side 0 clamps to 2: enough steps for a couple of completed mazes
    write_side(mbg_pkg::CFG_W'(0));
    for (int i = 0; i < 8; i++)
      send_word((i % 2) ? {mbg_pkg::RND_W{1'b1}} : {mbg_pkg::RND_W{1'b0}});

    // side 1 also clamps to 2
    write_side(mbg_pkg::CFG_W'(1));
    for (int i = 0; i < 4; i++) send_word(pick_word());

    // all-ones side clamps to the largest grid
    write_side('1);
    send_word('1);
    send_word('0);
    for (int i = 0; i < 3; i++) send_word(pick_word());

    // just above the largest grid
    write_side(mbg_pkg::CFG_W'(MAX_SIDE + 1));
    for (int i = 0; i < 3; i++) send_word(pick_word());

    // random phases, rotating through the idling modes
    for (int p = 0; p < 12; p++) begin
      write_side(mbg_pkg::CFG_W'(phase_sides[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off midway until the pipeline has emptied
        if (i == PHASE_ITEMS / 2) drain_results();
        send_word(pick_word());
      end
    end

    drain_results();
    repeat (2 * STEP_LATENCY) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
